// File: hw/rtl/tdpt_pkg.sv
// Shared constants and controller/datapath interface types for the
// trial-division prime test core. No dependencies.
package tdpt_pkg;

  localparam int unsigned DEFAULT_VALUE_WIDTH = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // Capture a new number and reset the divisor to two.
    logic div_start;   // Start a remainder computation for the current divisor.
    logic step;        // Advance to the next candidate divisor.
    logic set_prime;   // Record the result as prime.
    logic set_comp;    // Record the result as not prime.
  } tdpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trivial;     // Negative, zero or one: never prime.
    logic bound_over;  // Divisor squared exceeds the number.
    logic div_done;    // Remainder is ready this cycle.
    logic rem_zero;    // Remainder is zero; valid with div_done.
  } tdpt_status_t;

endpackage

// File: hw/rtl/tdpt_rem.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on nothing but its parameter.
module tdpt_rem #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic                   rem_zero_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] dvd_q, dvd_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] div_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  assign trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(VALUE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[VALUE_WIDTH-2:0], 1'b0};
      // The partial remainder stays below the divisor, so it fits the word.
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[VALUE_WIDTH-1:0];
      end else begin
        rem_d = trial[VALUE_WIDTH-1:0];
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

// File: hw/rtl/tdpt_datapath.sv
// Datapath of the prime test: number, divisor and divisor-squared registers,
// the result flag and the remainder unit. Uses tdpt_pkg and tdpt_rem.
module tdpt_datapath import tdpt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tdpt_cmd_t                     cmd_i,
  output tdpt_status_t                  status_o,
  input  logic signed [VALUE_WIDTH-1:0] number_i,
  output logic signed [VALUE_WIDTH-1:0] tested_value_o,
  output logic                          is_prime_o
);

  logic [VALUE_WIDTH-1:0] num_q;
  logic [VALUE_WIDTH-1:0] dvs_q, dvs_d;
  logic [VALUE_WIDTH-1:0] sq_q, sq_d;
  logic                   prime_q;
  logic                   div_done;
  logic                   rem_zero;

  // After two only odd divisors are tried; an even factor implies two divides.
  always_comb begin
    dvs_d = dvs_q;
    sq_d  = sq_q;
    if (cmd_i.load) begin
      dvs_d = VALUE_WIDTH'(2);
      sq_d  = VALUE_WIDTH'(4);
    end else if (cmd_i.step) begin
      if (dvs_q == VALUE_WIDTH'(2)) begin
        dvs_d = VALUE_WIDTH'(3);
        sq_d  = VALUE_WIDTH'(9);
      end else begin
        dvs_d = dvs_q + VALUE_WIDTH'(2);
        sq_d  = sq_q + {dvs_q[VALUE_WIDTH-3:0], 2'b00} + VALUE_WIDTH'(4);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= number_i;
    end
    dvs_q <= dvs_d;
    sq_q  <= sq_d;
    if (cmd_i.set_prime) begin
      prime_q <= 1'b1;
    end else if (cmd_i.set_comp) begin
      prime_q <= 1'b0;
    end
  end

  tdpt_rem #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (dvs_q),
    .done_o     (div_done),
    .rem_zero_o (rem_zero)
  );

  assign status_o.trivial    = num_q[VALUE_WIDTH-1] || (num_q[VALUE_WIDTH-1:1] == '0);
  assign status_o.bound_over = (sq_q > num_q);
  assign status_o.div_done   = div_done;
  assign status_o.rem_zero   = rem_zero;

  assign tested_value_o = num_q;
  assign is_prime_o     = prime_q;

endmodule

// File: hw/rtl/tdpt_ctrl.sv
// Controller state machine of the prime test. Drives the datapath by
// commands and reads its status. Uses tdpt_pkg.
module tdpt_ctrl import tdpt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  output logic         done_o,
  input  tdpt_status_t status_i,
  output tdpt_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_REPORT = 4'b1000
  } tdpt_state_e;

  tdpt_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.trivial) begin
          cmd_o.set_comp = 1'b1;
          state_d        = ST_REPORT;
        end else if (status_i.bound_over) begin
          cmd_o.set_prime = 1'b1;
          state_d         = ST_REPORT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            cmd_o.set_comp = 1'b1;
            state_d        = ST_REPORT;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = ST_CHECK;
          end
        end
      end
      ST_REPORT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_REPORT);

endmodule

// File: hw/rtl/trial_division_prime_test_core.sv
// Trial-division prime test core: a number is taken when start is high and
// busy is low; one cycle later the test begins and the result appears for
// exactly one cycle with done_o high, so the receiver must take it then.
// Negative numbers, zero and one report not prime without any division. Other
// numbers are divided by two and then by odd divisors while the divisor
// squared does not exceed the number; each divisor takes a full pass of the
// bit-serial remainder unit, and the next divisor is tried only after that
// remainder is ready. At most about 23200 divisors are tried for 32-bit
// numbers. Busy stays high through the result cycle. Uses tdpt_pkg,
// tdpt_ctrl and tdpt_datapath.
module trial_division_prime_test_core import tdpt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] number_i,
  output logic                          done_o,
  output logic signed [VALUE_WIDTH-1:0] tested_value_o,
  output logic                          is_prime_o
);

  tdpt_cmd_t    cmd;
  tdpt_status_t status;

  tdpt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tdpt_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .number_i       (number_i),
    .tested_value_o (tested_value_o),
    .is_prime_o     (is_prime_o)
  );

endmodule
